// ----- src/scwe_pkg.sv -----
// ----------------------------------------------------------------------------
// scwe_pkg
// shared widths, limits and operation codes of the successor chain walk engine
// ----------------------------------------------------------------------------
package scwe_pkg;

   localparam int NODE_W      = 5;
   localparam int WEIGHT_W    = 16;
   localparam int COST_W      = 21;
   localparam int STEP_OUT_W  = 6;

   localparam int NODES_DEF     = 32;
   localparam int COST_BITS_DEF = 16;

   localparam logic [COST_W-1:0] COST_MAX = {COST_W{1'b1}};

   typedef enum logic [1:0] {
      FUNC_LOAD  = 2'd0,
      FUNC_QUERY = 2'd1,
      FUNC_PATH  = 2'd2,
      FUNC_NONE  = 2'd3
   } func_type;

endpackage

// ----- src/successor_chain_walk_engine_top.sv -----
// ----------------------------------------------------------------------------
// successor_chain_walk_engine_top
// node table with one outgoing edge per node; walks successor chains for
// reachability, step count, saturated cost sum and path listing
// ----------------------------------------------------------------------------
//
//  channel  direction  handshake            word
//  req_     in         req_valid/req_ready  load, query or path request
//  rsp_     out        rsp_valid/rsp_ready  walk result or one node of a path
//
//  a load is taken and written without leaving idle; an unused func code is dropped
//  a query walks the successor chain through the edge memory
//  (one synchronous read per cycle), then waits until its result is taken
//  a path listing then shows one word per node listed, one memory read each
//  one request is handled at a time; req_ready is low while a walk or its
//  results are in flight, and a stalled rsp_ready holds the result word
//  synchronous reset clears edge present bits and visited marks at once
//
module successor_chain_walk_engine_top
   import scwe_pkg::*;
#(
   parameter int NODES     = NODES_DEF,
   parameter int COST_BITS = COST_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,

   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [1:0]            req_func,
   input  logic [NODE_W-1:0]     req_entry_node,
   input  logic                  req_has_successor,
   input  logic [NODE_W-1:0]     req_successor_node,
   input  logic [WEIGHT_W-1:0]   req_edge_weight,
   input  logic [NODE_W-1:0]     req_source_node,
   input  logic [NODE_W-1:0]     req_target_node,
   input  logic [COST_W-1:0]     req_budget,

   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic                  rsp_reachable,
   output logic [STEP_OUT_W-1:0] rsp_step_count,
   output logic [COST_W-1:0]     rsp_total_cost,
   output logic                  rsp_within_budget,
   output logic [NODE_W-1:0]     rsp_path_node,
   output logic                  rsp_last
);

   localparam int AW     = $clog2(NODES);
   localparam int STEP_W = $clog2(NODES + 2);
   localparam int SUM_W  = ((COST_BITS > COST_W) ? COST_BITS : COST_W) + 1;
   localparam int ENT_W  = NODE_W + COST_BITS;
   localparam logic [NODE_W:0] NODE_LIMIT = (NODE_W + 1)'(NODES);

   typedef enum logic [4:0] {
      ST_IDLE     = 5'b00001,
      ST_WALK     = 5'b00010,
      ST_RESP     = 5'b00100,
      ST_PATH_OUT = 5'b01000,
      ST_PATH_RD  = 5'b10000
   } state_type;

   function automatic logic [AW-1:0] node_addr(input logic [NODE_W-1:0] node);
      logic [AW+NODE_W-1:0] ext;
      ext = {{AW{1'b0}}, node};
      return ext[AW-1:0];
   endfunction

   function automatic logic in_range(input logic [NODE_W-1:0] node);
      return ({1'b0, node} < NODE_LIMIT);
   endfunction

   state_type              state_ff, state_in;
   logic [NODES-1:0]       valid_ff, valid_in;
   logic [NODES-1:0]       visited_ff, visited_in;
   logic                   path_ff, path_in;
   logic [NODE_W-1:0]      tgt_ff, tgt_in;
   logic [COST_W-1:0]      budget_ff, budget_in;
   logic [NODE_W-1:0]      cur_ff, cur_in;
   logic [STEP_W-1:0]      n_ff, n_in;
   logic [STEP_W-1:0]      k_ff, k_in;
   logic [COST_W-1:0]      sum_ff, sum_in;
   // source node kept in the node register until the first path word
   logic [NODE_W-1:0]      src_ff, src_in;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   rsp_reachable_ff, rsp_reachable_in;
   logic [STEP_W-1:0]      rsp_step_ff, rsp_step_in;
   logic [COST_W-1:0]      rsp_cost_ff, rsp_cost_in;
   logic                   rsp_inb_ff, rsp_inb_in;
   logic [NODE_W-1:0]      rsp_node_ff, rsp_node_in;
   logic                   rsp_last_ff, rsp_last_in;

   logic [ENT_W-1:0]       edge_mem [NODES];
   logic [ENT_W-1:0]       rd_ff;
   logic [AW-1:0]          rd_addr;
   logic                   mem_we;
   logic [AW-1:0]          mem_waddr;
   logic [ENT_W-1:0]       mem_wdata;

   logic [NODE_W-1:0]      rd_succ;
   logic [COST_BITS-1:0]   rd_cost;
   logic [SUM_W-1:0]       sum_wide;
   logic [COST_W-1:0]      sum_sat;
   logic [COST_BITS+WEIGHT_W-1:0] weight_ext;
   logic [STEP_W+STEP_OUT_W-1:0]  step_ext;
   logic [STEP_W-1:0]      k_next;
   logic                   req_take;
   logic                   rsp_take;

   assign req_ready = (state_ff == ST_IDLE);
   assign req_take  = req_valid && req_ready;
   assign rsp_take  = rsp_valid_ff && rsp_ready;

   assign rd_succ    = rd_ff[COST_BITS +: NODE_W];
   assign rd_cost    = rd_ff[COST_BITS-1:0];
   assign sum_wide   = SUM_W'(sum_ff) + SUM_W'(rd_cost);
   assign sum_sat    = (sum_wide > SUM_W'(COST_MAX)) ? COST_MAX : sum_wide[COST_W-1:0];
   assign weight_ext = {{COST_BITS{1'b0}}, req_edge_weight};
   assign k_next     = k_ff + STEP_W'(1);

   // edge memory, one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (mem_we) begin
         edge_mem[mem_waddr] <= mem_wdata;
      end
      rd_ff <= edge_mem[rd_addr];
   end

   always_comb begin
      unique case (state_ff)
         ST_IDLE: rd_addr = node_addr(req_source_node);
         ST_WALK: rd_addr = node_addr(rd_succ);
         default: rd_addr = node_addr(cur_ff);
      endcase
   end

   always_comb begin
      state_in         = state_ff;
      valid_in         = valid_ff;
      visited_in       = visited_ff;
      path_in          = path_ff;
      tgt_in           = tgt_ff;
      budget_in        = budget_ff;
      cur_in           = cur_ff;
      n_in             = n_ff;
      k_in             = k_ff;
      sum_in           = sum_ff;
      rsp_valid_in     = rsp_valid_ff;
      rsp_reachable_in = rsp_reachable_ff;
      rsp_step_in      = rsp_step_ff;
      rsp_cost_in      = rsp_cost_ff;
      rsp_inb_in       = rsp_inb_ff;
      rsp_node_in      = rsp_node_ff;
      rsp_last_in      = rsp_last_ff;
      mem_we           = 1'b0;
      mem_waddr        = node_addr(req_entry_node);
      mem_wdata        = {req_successor_node, weight_ext[COST_BITS-1:0]};

      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               unique case (func_type'(req_func)) inside
                  FUNC_LOAD: begin
                     if (in_range(req_entry_node)) begin
                        mem_we = 1'b1;
                        valid_in[node_addr(req_entry_node)] = req_has_successor;
                     end
                  end
                  FUNC_QUERY, FUNC_PATH: begin
                     visited_in = '0;
                     path_in    = (func_type'(req_func) == FUNC_PATH);
                     tgt_in     = req_target_node;
                     budget_in  = req_budget;
                     cur_in     = req_source_node;
                     n_in       = STEP_W'(1);
                     sum_in     = '0;
                     if (in_range(req_source_node) && in_range(req_target_node) &&
                         valid_ff[node_addr(req_source_node)]) begin
                        state_in = ST_WALK;
                     end else begin
                        rsp_valid_in     = 1'b1;
                        rsp_reachable_in = 1'b0;
                        rsp_step_in      = '0;
                        rsp_cost_in      = '0;
                        rsp_inb_in       = 1'b0;
                        rsp_node_in      = '0;
                        rsp_last_in      = 1'b1;
                        state_in         = ST_RESP;
                     end
                  end
                  FUNC_NONE: begin
                  end
               endcase
            end
         end

         ST_WALK: begin
            if (rd_succ == tgt_ff) begin
               rsp_valid_in     = 1'b1;
               rsp_reachable_in = 1'b1;
               rsp_step_in      = n_ff;
               rsp_cost_in      = sum_sat;
               rsp_inb_in       = (budget_ff >= sum_sat);
               k_in             = '0;
               if (path_ff) begin
                  // cur still holds the source on the first edge only; reload it
                  rsp_node_in = src_ff;
                  rsp_last_in = 1'b0;
                  state_in    = ST_PATH_RD;
                  rsp_valid_in = 1'b0;
               end else begin
                  rsp_node_in = '0;
                  rsp_last_in = 1'b1;
                  state_in    = ST_RESP;
               end
            end else if (visited_ff[node_addr(cur_ff)] || !in_range(rd_succ) ||
                         !valid_ff[node_addr(rd_succ)]) begin
               rsp_valid_in     = 1'b1;
               rsp_reachable_in = 1'b0;
               rsp_step_in      = '0;
               rsp_cost_in      = '0;
               rsp_inb_in       = 1'b0;
               rsp_node_in      = '0;
               rsp_last_in      = 1'b1;
               state_in         = ST_RESP;
            end else begin
               visited_in[node_addr(cur_ff)] = 1'b1;
               cur_in = rd_succ;
               n_in   = n_ff + STEP_W'(1);
               sum_in = sum_sat;
            end
         end

         ST_RESP: begin
            if (rsp_take) begin
               rsp_valid_in = 1'b0;
               state_in     = ST_IDLE;
            end
         end

         ST_PATH_OUT: begin
            if (rsp_take) begin
               rsp_valid_in = 1'b0;
               if (rsp_last_ff) begin
                  state_in = ST_IDLE;
               end else begin
                  k_in     = k_next;
                  state_in = ST_PATH_RD;
               end
            end
         end

         ST_PATH_RD: begin
            // k counts the word about to be shown; word zero is the source
            rsp_valid_in = 1'b1;
            if (k_ff == '0) begin
               cur_in      = rsp_node_ff;
               rsp_node_in = rsp_node_ff;
               rsp_last_in = 1'b0;
            end else begin
               cur_in      = rd_succ;
               rsp_node_in = (k_ff == rsp_step_ff) ? tgt_ff : rd_succ;
               rsp_last_in = (k_ff == rsp_step_ff);
            end
            state_in = ST_PATH_OUT;
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         valid_ff     <= '0;
         visited_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         valid_ff     <= valid_in;
         visited_ff   <= visited_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      src_in = src_ff;
      if (req_take) begin
         src_in = req_source_node;
      end
   end

   always_ff @(posedge clock) begin
      path_ff          <= path_in;
      tgt_ff           <= tgt_in;
      budget_ff        <= budget_in;
      cur_ff           <= cur_in;
      n_ff             <= n_in;
      k_ff             <= k_in;
      sum_ff           <= sum_in;
      src_ff           <= src_in;
      rsp_reachable_ff <= rsp_reachable_in;
      rsp_step_ff      <= rsp_step_in;
      rsp_cost_ff      <= rsp_cost_in;
      rsp_inb_ff       <= rsp_inb_in;
      rsp_node_ff      <= rsp_node_in;
      rsp_last_ff      <= rsp_last_in;
   end

   assign step_ext          = {{STEP_OUT_W{1'b0}}, rsp_step_ff};
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_reachable     = rsp_reachable_ff;
   assign rsp_step_count    = step_ext[STEP_OUT_W-1:0];
   assign rsp_total_cost    = rsp_cost_ff;
   assign rsp_within_budget = rsp_inb_ff;
   assign rsp_path_node     = rsp_node_ff;
   assign rsp_last          = rsp_last_ff;

   // no request is taken while a result word is on offer
   assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid))
      else $error("request taken while result word pending");

   // an unreachable result is a single all-zero final word
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_reachable) |->
         (rsp_last && rsp_step_count == '0 && rsp_total_cost == '0 &&
          !rsp_within_budget && rsp_path_node == '0))
      else $error("unreachable result word not cleared");

   // a reachable walk never reports zero steps
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_reachable) |-> (rsp_step_count != '0))
      else $error("reachable result with zero steps");

   // path words follow one another until the final one is taken
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && !rsp_last) |=> (!req_ready))
      else $error("path listing ended early");

endmodule
